[hdl/sscp_pkg.sv]
package sscp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EPS_WIDTH   = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int WIDE_W      = 2 * DOT_W + 2;
    localparam int PPROD_W     = DIFF_W + FRAC_BITS + 2;
    localparam int DIST_W      = 63;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int HALF_W      = DOT_W / 2;

    // Register index of zero_epsilon, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_ZERO_EPS = '0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [DOT_W-1:0]       t_dot;
    typedef logic signed [WIDE_W-1:0]      t_wide;
    typedef logic signed [PPROD_W-1:0]     t_pprod;
    typedef logic [FRAC_BITS:0]            t_param;

    localparam t_param PARAM_ONE = t_param'(1) << FRAC_BITS;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_start_z;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord a_end_z;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_start_z;
        t_coord b_end_x;
        t_coord b_end_y;
        t_coord b_end_z;
    } t_seg_in;

    typedef struct packed {
        t_coord              near_a_x;
        t_coord              near_a_y;
        t_coord              near_a_z;
        t_coord              near_b_x;
        t_coord              near_b_y;
        t_coord              near_b_z;
        t_param              param_on_a;
        t_param              param_on_b;
        logic [DIST_W-1:0]   squared_distance;
    } t_seg_out;

    // Segment geometry that rides along the pipeline; index 0 is x.
    typedef struct packed {
        t_coord [2:0] p0;
        t_coord [2:0] p2;
        t_diff  [2:0] d1;
        t_diff  [2:0] d2;
    } t_geo;

    typedef struct packed {
        t_geo geo;
        t_dot a;
        t_dot b;
        t_dot c;
        t_dot e;
        t_dot f;
        logic pa;
        logic pe;
    } t_ctx;

    // Which parameter the second quotient feeds, and the value of the other.
    typedef struct packed {
        t_geo   geo;
        logic   to_t;
        t_param fixed;
    } t_sel;

    typedef struct packed {
        logic [WIDE_W-1:0]    rem;
        logic [WIDE_W-1:0]    den;
        logic [FRAC_BITS-1:0] q;
        logic                 zero;
        logic                 full;
    } t_div;

    // Partial products of a dot-product by dot-product multiply, split into
    // a signed upper half and an unsigned lower half of each operand.
    typedef struct packed {
        logic signed [2*HALF_W-1:0] hh;
        logic signed [2*HALF_W:0]   hl;
        logic signed [2*HALF_W:0]   lh;
        logic        [2*HALF_W-1:0] ll;
    } t_pp;

    function automatic t_pp pp_mul(t_dot x, t_dot y);
        t_pp                      r;
        logic signed [HALF_W-1:0] xh;
        logic signed [HALF_W-1:0] yh;
        logic signed [HALF_W:0]   xl;
        logic signed [HALF_W:0]   yl;
        xh   = x[DOT_W-1:HALF_W];
        yh   = y[DOT_W-1:HALF_W];
        xl   = {1'b0, x[HALF_W-1:0]};
        yl   = {1'b0, y[HALF_W-1:0]};
        r.hh = xh * yh;
        r.hl = xh * yl;
        r.lh = xl * yh;
        r.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
        return r;
    endfunction

    function automatic t_wide pp_sum(t_pp p);
        return (t_wide'(p.hh) <<< (2 * HALF_W)) + (t_wide'(p.hl) <<< HALF_W)
               + (t_wide'(p.lh) <<< HALF_W) + t_wide'(p.ll);
    endfunction

    function automatic t_div div_init(t_wide num, t_wide den);
        t_div r;
        r.zero = (num <= 0);
        r.full = !r.zero && (num >= den);
        r.rem  = num;
        r.den  = den;
        r.q    = '0;
        return r;
    endfunction

    // One restoring step: the remainder stays below the divisor.
    function automatic t_div div_step(t_div d);
        t_div              r;
        logic [WIDE_W-1:0] two;
        r   = d;
        two = d.rem << 1;
        if (two >= d.den) begin
            r.rem = two - d.den;
            r.q   = {d.q[FRAC_BITS-2:0], 1'b1};
        end else begin
            r.rem = two;
            r.q   = {d.q[FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_param div_result(t_div d);
        t_param r;
        if (d.zero) begin
            r = '0;
        end else if (d.full) begin
            r = PARAM_ONE;
        end else begin
            r = {1'b0, d.q};
        end
        return r;
    endfunction

endpackage

[hdl/segment_segment_closest_points_core.sv]
// Closest points between two 3D segments, signed Q16.16. A transfer is
// accepted on every clock edge where start is high; busy never rises, so a
// new segment pair can be presented in every cycle. Each result appears on
// o_result for exactly one cycle with o_done high, in input order. The
// receiver cannot stall the block and must take each result in the cycle
// it is shown. The pipeline is made of two chained restoring dividers of
// 16 stages each (one quotient bit per stage), plus twelve stages for the
// differences, dot products, the split Cramer products and their
// recombination, the case selection and the closest-point arithmetic.
// zero_epsilon lives at byte address 0 of the APB port and should only be
// written while no transfer is in flight.
module segment_segment_closest_points_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sscp_pkg::t_seg_in               i_seg,
    output logic                            o_done,
    output sscp_pkg::t_seg_out              o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sscp_pkg::ADDR_W-1:0]     paddr,
    input  logic [sscp_pkg::DATA_W-1:0]     pwdata,
    output logic [sscp_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int F   = sscp_pkg::FRAC_BITS;
    localparam int LAT = 12 + 2 * F;

    // Configuration register.
    logic [sscp_pkg::EPS_WIDTH-1:0] r_eps;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= sscp_pkg::EPS_WIDTH'(1);
        end else if (psel && penable && pwrite &&
                     paddr[sscp_pkg::ADDR_W-1:2] == sscp_pkg::REG_ZERO_EPS) begin
            r_eps <= pwdata[sscp_pkg::EPS_WIDTH-1:0];
        end
    end

    always_comb begin
        if (paddr[sscp_pkg::ADDR_W-1:2] == sscp_pkg::REG_ZERO_EPS) begin
            prdata = sscp_pkg::DATA_W'(r_eps);
        end else begin
            prdata = '0;
        end
    end

    // Stage 1: direction vectors and the start-to-start offset.
    logic                  r1_v;
    sscp_pkg::t_geo        r1_geo;
    sscp_pkg::t_diff [2:0] r1_r;
    sscp_pkg::t_coord      n_as [3];
    sscp_pkg::t_coord      n_ae [3];
    sscp_pkg::t_coord      n_bs [3];
    sscp_pkg::t_coord      n_be [3];

    always_comb begin
        n_as[0] = i_seg.a_start_x; n_as[1] = i_seg.a_start_y; n_as[2] = i_seg.a_start_z;
        n_ae[0] = i_seg.a_end_x;   n_ae[1] = i_seg.a_end_y;   n_ae[2] = i_seg.a_end_z;
        n_bs[0] = i_seg.b_start_x; n_bs[1] = i_seg.b_start_y; n_bs[2] = i_seg.b_start_z;
        n_be[0] = i_seg.b_end_x;   n_be[1] = i_seg.b_end_y;   n_be[2] = i_seg.b_end_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        for (int k = 0; k < 3; k++) begin
            r1_geo.p0[k] <= n_as[k];
            r1_geo.p2[k] <= n_bs[k];
            r1_geo.d1[k] <= sscp_pkg::t_diff'(n_ae[k]) - sscp_pkg::t_diff'(n_as[k]);
            r1_geo.d2[k] <= sscp_pkg::t_diff'(n_be[k]) - sscp_pkg::t_diff'(n_bs[k]);
            r1_r[k]      <= sscp_pkg::t_diff'(n_as[k]) - sscp_pkg::t_diff'(n_bs[k]);
        end
    end

    // Stage 2: the fifteen component products of the five dot products.
    logic            r2_v;
    sscp_pkg::t_geo  r2_geo;
    sscp_pkg::t_prod r2_aa [3];
    sscp_pkg::t_prod r2_ee [3];
    sscp_pkg::t_prod r2_ff [3];
    sscp_pkg::t_prod r2_cc [3];
    sscp_pkg::t_prod r2_bb [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_geo <= r1_geo;
        for (int k = 0; k < 3; k++) begin
            r2_aa[k] <= $signed(r1_geo.d1[k]) * $signed(r1_geo.d1[k]);
            r2_ee[k] <= $signed(r1_geo.d2[k]) * $signed(r1_geo.d2[k]);
            r2_ff[k] <= $signed(r1_geo.d2[k]) * $signed(r1_r[k]);
            r2_cc[k] <= $signed(r1_geo.d1[k]) * $signed(r1_r[k]);
            r2_bb[k] <= $signed(r1_geo.d1[k]) * $signed(r1_geo.d2[k]);
        end
    end

    // Stage 3: dot product sums.
    logic           r3_v;
    sscp_pkg::t_ctx r3_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ctx.geo <= r2_geo;
        r3_ctx.a   <= sscp_pkg::t_dot'(r2_aa[0]) + sscp_pkg::t_dot'(r2_aa[1])
                      + sscp_pkg::t_dot'(r2_aa[2]);
        r3_ctx.e   <= sscp_pkg::t_dot'(r2_ee[0]) + sscp_pkg::t_dot'(r2_ee[1])
                      + sscp_pkg::t_dot'(r2_ee[2]);
        r3_ctx.f   <= sscp_pkg::t_dot'(r2_ff[0]) + sscp_pkg::t_dot'(r2_ff[1])
                      + sscp_pkg::t_dot'(r2_ff[2]);
        r3_ctx.c   <= sscp_pkg::t_dot'(r2_cc[0]) + sscp_pkg::t_dot'(r2_cc[1])
                      + sscp_pkg::t_dot'(r2_cc[2]);
        r3_ctx.b   <= sscp_pkg::t_dot'(r2_bb[0]) + sscp_pkg::t_dot'(r2_bb[1])
                      + sscp_pkg::t_dot'(r2_bb[2]);
        r3_ctx.pa  <= 1'b0;
        r3_ctx.pe  <= 1'b0;
    end

    // Stage 4: point tests against epsilon and the partial products of the
    // Cramer terms, each operand split into two halves.
    logic            r4_v;
    sscp_pkg::t_ctx  r4_ctx;
    sscp_pkg::t_pp   r4_pae;
    sscp_pkg::t_pp   r4_pbb;
    sscp_pkg::t_pp   r4_pbf;
    sscp_pkg::t_pp   r4_pce;
    sscp_pkg::t_dot  n_epsw;
    sscp_pkg::t_ctx  n_ctx4;

    assign n_epsw = sscp_pkg::t_dot'({r_eps, F'(0)});

    always_comb begin
        n_ctx4    = r3_ctx;
        n_ctx4.pa = (r3_ctx.a <= n_epsw);
        n_ctx4.pe = (r3_ctx.e <= n_epsw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_ctx <= n_ctx4;
        r4_pae <= sscp_pkg::pp_mul(r3_ctx.a, r3_ctx.e);
        r4_pbb <= sscp_pkg::pp_mul(r3_ctx.b, r3_ctx.b);
        r4_pbf <= sscp_pkg::pp_mul(r3_ctx.b, r3_ctx.f);
        r4_pce <= sscp_pkg::pp_mul(r3_ctx.c, r3_ctx.e);
    end

    // Stage 4b: recombine the partial products into the Cramer products.
    logic            r4b_v;
    sscp_pkg::t_ctx  r4b_ctx;
    sscp_pkg::t_wide r4b_ae;
    sscp_pkg::t_wide r4b_bb;
    sscp_pkg::t_wide r4b_bf;
    sscp_pkg::t_wide r4b_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4b_v <= 1'b0;
        end else begin
            r4b_v <= r4_v;
        end
        r4b_ctx <= r4_ctx;
        r4b_ae  <= sscp_pkg::pp_sum(r4_pae);
        r4b_bb  <= sscp_pkg::pp_sum(r4_pbb);
        r4b_bf  <= sscp_pkg::pp_sum(r4_pbf);
        r4b_ce  <= sscp_pkg::pp_sum(r4_pce);
    end

    // Stage 5: set up the first division, s = (bf - ce) / (ae - bb).
    logic            r5_v;
    sscp_pkg::t_ctx  r5_ctx;
    sscp_pkg::t_div  r5_div;
    sscp_pkg::t_wide n_den1;
    sscp_pkg::t_div  n_div1;

    always_comb begin
        n_den1 = r4b_ae - r4b_bb;
        n_div1 = sscp_pkg::div_init(r4b_bf - r4b_ce, n_den1);
        // Parallel segments start from s equal to zero.
        if (n_den1 == 0) begin
            n_div1.zero = 1'b1;
            n_div1.full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4b_v;
        end
        r5_ctx <= r4b_ctx;
        r5_div <= n_div1;
    end

    // First divider: one quotient bit per stage.
    logic           r_d1_v   [F];
    sscp_pkg::t_ctx r_d1_ctx [F];
    sscp_pkg::t_div r_d1_div [F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < F; k++) begin
                r_d1_v[k] <= 1'b0;
            end
        end else begin
            r_d1_v[0] <= r5_v;
            for (int k = 1; k < F; k++) begin
                r_d1_v[k] <= r_d1_v[k-1];
            end
        end
        r_d1_ctx[0] <= r5_ctx;
        r_d1_div[0] <= sscp_pkg::div_step(r5_div);
        for (int k = 1; k < F; k++) begin
            r_d1_ctx[k] <= r_d1_ctx[k-1];
            r_d1_div[k] <= sscp_pkg::div_step(r_d1_div[k-1]);
        end
    end

    // Stage A: tn = b*s + f at scale 2^-3F, and e at the same scale.
    logic             rA_v;
    sscp_pkg::t_ctx   rA_ctx;
    sscp_pkg::t_param rA_s1;
    sscp_pkg::t_wide  rA_tn;
    sscp_pkg::t_wide  rA_ef;
    sscp_pkg::t_param n_s1;
    sscp_pkg::t_wide  n_b_s1;

    always_comb begin
        n_s1   = sscp_pkg::div_result(r_d1_div[F-1]);
        n_b_s1 = r_d1_ctx[F-1].b * $signed({1'b0, n_s1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
        end else begin
            rA_v <= r_d1_v[F-1];
        end
        rA_ctx <= r_d1_ctx[F-1];
        rA_s1  <= n_s1;
        rA_tn  <= n_b_s1 + (sscp_pkg::t_wide'(r_d1_ctx[F-1].f) <<< F);
        rA_ef  <= sscp_pkg::t_wide'(r_d1_ctx[F-1].e) <<< F;
    end

    // Stage B: pick the case and set up the second division.
    logic             r6_v;
    sscp_pkg::t_sel   r6_sel;
    sscp_pkg::t_div   r6_div;
    sscp_pkg::t_sel   n_sel;
    sscp_pkg::t_wide  n_num2;
    sscp_pkg::t_wide  n_den2;

    always_comb begin
        n_sel.geo = rA_ctx.geo;
        if (rA_ctx.pa && rA_ctx.pe) begin
            // Both segments are points.
            n_num2      = '0;
            n_den2      = sscp_pkg::t_wide'(1);
            n_sel.to_t  = 1'b0;
            n_sel.fixed = '0;
        end else if (rA_ctx.pa) begin
            n_num2      = sscp_pkg::t_wide'(rA_ctx.f);
            n_den2      = sscp_pkg::t_wide'(rA_ctx.e);
            n_sel.to_t  = 1'b1;
            n_sel.fixed = '0;
        end else if (rA_ctx.pe || rA_tn < 0) begin
            n_num2      = -sscp_pkg::t_wide'(rA_ctx.c);
            n_den2      = sscp_pkg::t_wide'(rA_ctx.a);
            n_sel.to_t  = 1'b0;
            n_sel.fixed = '0;
        end else if (rA_tn > rA_ef) begin
            n_num2      = sscp_pkg::t_wide'(rA_ctx.b) - sscp_pkg::t_wide'(rA_ctx.c);
            n_den2      = sscp_pkg::t_wide'(rA_ctx.a);
            n_sel.to_t  = 1'b0;
            n_sel.fixed = sscp_pkg::PARAM_ONE;
        end else begin
            n_num2      = rA_tn;
            n_den2      = rA_ef;
            n_sel.to_t  = 1'b1;
            n_sel.fixed = rA_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= rA_v;
        end
        r6_sel <= n_sel;
        r6_div <= sscp_pkg::div_init(n_num2, n_den2);
    end

    // Second divider.
    logic           r_d2_v   [F];
    sscp_pkg::t_sel r_d2_sel [F];
    sscp_pkg::t_div r_d2_div [F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < F; k++) begin
                r_d2_v[k] <= 1'b0;
            end
        end else begin
            r_d2_v[0] <= r6_v;
            for (int k = 1; k < F; k++) begin
                r_d2_v[k] <= r_d2_v[k-1];
            end
        end
        r_d2_sel[0] <= r6_sel;
        r_d2_div[0] <= sscp_pkg::div_step(r6_div);
        for (int k = 1; k < F; k++) begin
            r_d2_sel[k] <= r_d2_sel[k-1];
            r_d2_div[k] <= sscp_pkg::div_step(r_d2_div[k-1]);
        end
    end

    // Stage P1: final s and t, direction times parameter.
    logic             rP1_v;
    sscp_pkg::t_geo   rP1_geo;
    sscp_pkg::t_param rP1_s;
    sscp_pkg::t_param rP1_t;
    sscp_pkg::t_pprod rP1_ma [3];
    sscp_pkg::t_pprod rP1_mb [3];
    sscp_pkg::t_param n_q2;
    sscp_pkg::t_param n_s;
    sscp_pkg::t_param n_t;

    always_comb begin
        n_q2 = sscp_pkg::div_result(r_d2_div[F-1]);
        n_s  = r_d2_sel[F-1].to_t ? r_d2_sel[F-1].fixed : n_q2;
        n_t  = r_d2_sel[F-1].to_t ? n_q2 : r_d2_sel[F-1].fixed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP1_v <= 1'b0;
        end else begin
            rP1_v <= r_d2_v[F-1];
        end
        rP1_geo <= r_d2_sel[F-1].geo;
        rP1_s   <= n_s;
        rP1_t   <= n_t;
        for (int k = 0; k < 3; k++) begin
            rP1_ma[k] <= $signed(r_d2_sel[F-1].geo.d1[k]) * $signed({1'b0, n_s});
            rP1_mb[k] <= $signed(r_d2_sel[F-1].geo.d2[k]) * $signed({1'b0, n_t});
        end
    end

    // Stage P2: closest points; they lie between the endpoints.
    logic             rP2_v;
    sscp_pkg::t_param rP2_s;
    sscp_pkg::t_param rP2_t;
    sscp_pkg::t_coord rP2_na [3];
    sscp_pkg::t_coord rP2_nb [3];
    sscp_pkg::t_pprod n_na   [3];
    sscp_pkg::t_pprod n_nb   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_na[k] = sscp_pkg::t_pprod'($signed(rP1_geo.p0[k])) + (rP1_ma[k] >>> F);
            n_nb[k] = sscp_pkg::t_pprod'($signed(rP1_geo.p2[k])) + (rP1_mb[k] >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP2_v <= 1'b0;
        end else begin
            rP2_v <= rP1_v;
        end
        rP2_s <= rP1_s;
        rP2_t <= rP1_t;
        for (int k = 0; k < 3; k++) begin
            rP2_na[k] <= n_na[k][sscp_pkg::COORD_WIDTH-1:0];
            rP2_nb[k] <= n_nb[k][sscp_pkg::COORD_WIDTH-1:0];
        end
    end

    // Stage P3: squared component differences.
    logic             rP3_v;
    sscp_pkg::t_param rP3_s;
    sscp_pkg::t_param rP3_t;
    sscp_pkg::t_coord rP3_na [3];
    sscp_pkg::t_coord rP3_nb [3];
    sscp_pkg::t_prod  rP3_sq [3];
    sscp_pkg::t_diff  n_dd   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_dd[k] = sscp_pkg::t_diff'(rP2_na[k]) - sscp_pkg::t_diff'(rP2_nb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP3_v <= 1'b0;
        end else begin
            rP3_v <= rP2_v;
        end
        rP3_s <= rP2_s;
        rP3_t <= rP2_t;
        for (int k = 0; k < 3; k++) begin
            rP3_na[k] <= rP2_na[k];
            rP3_nb[k] <= rP2_nb[k];
            rP3_sq[k] <= n_dd[k] * n_dd[k];
        end
    end

    // Stage P4: distance sum, rescale, saturate, and the output register.
    logic               r_done;
    sscp_pkg::t_seg_out r_out;
    sscp_pkg::t_dot     n_sum;
    sscp_pkg::t_dot     n_shr;
    logic [sscp_pkg::DIST_W-1:0] n_dist;

    always_comb begin
        n_sum = sscp_pkg::t_dot'(rP3_sq[0]) + sscp_pkg::t_dot'(rP3_sq[1])
                + sscp_pkg::t_dot'(rP3_sq[2]);
        n_shr = n_sum >>> F;
        if (n_shr[sscp_pkg::DOT_W-1:sscp_pkg::DIST_W] != '0) begin
            n_dist = '1;
        end else begin
            n_dist = n_shr[sscp_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rP3_v;
        end
        r_out.near_a_x         <= rP3_na[0];
        r_out.near_a_y         <= rP3_na[1];
        r_out.near_a_z         <= rP3_na[2];
        r_out.near_b_x         <= rP3_nb[0];
        r_out.near_b_y         <= rP3_nb[1];
        r_out.near_b_z         <= rP3_nb[2];
        r_out.param_on_a       <= rP3_s;
        r_out.param_on_b       <= rP3_t;
        r_out.squared_distance <= n_dist;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // Every accepted transfer yields its strobe after the full pipeline depth.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_done)
        else $error("result strobe missing after pipeline latency");

    // A strobe never appears without a matching accepted transfer.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, LAT)) |-> $past(start, LAT))
        else $error("result strobe without accepted transfer");

    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.param_on_a <= sscp_pkg::PARAM_ONE &&
                    o_result.param_on_b <= sscp_pkg::PARAM_ONE))
        else $error("segment parameter above one");

endmodule
